FILE: hdl/signed_varint_encoder_unit_assert.svh
// Assertion macros used by the encoder RTL.
`ifndef SIGNED_VARINT_ENCODER_UNIT_ASSERT_SVH
`define SIGNED_VARINT_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SVENC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("encoder assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SVENC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("encoder assertion failed");

`endif

FILE: hdl/svenc_pkg.sv
`default_nettype none

package svenc_pkg;

    localparam int VALUE_BITS = 64;
    localparam int GROUP_BITS = 7;
    localparam int BYTE_BITS  = 8;
    localparam int MAX_BYTES  = 10;
    localparam int COUNT_W    = 4;

    // Index of the tenth byte, which holds only the top bit of the value.
    localparam logic [COUNT_W-1:0] LAST_INDEX = 4'd9;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic advance;
    } t_shift_ctrl;

    typedef struct packed {
        logic [GROUP_BITS-1:0] group;
        logic                  uniform;
        logic                  low_bit;
    } t_digit;

endpackage

`default_nettype wire

FILE: hdl/svenc_in_if.sv
`default_nettype none

interface svenc_in_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

FILE: hdl/svenc_out_if.sv
`default_nettype none

interface svenc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last;

    modport source (output valid, output code_byte, output last, input ready);
    modport sink   (input valid, input code_byte, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/svenc_shift.sv
`default_nettype none

module svenc_shift (
    input  wire logic                               i_clk,
    input  wire svenc_pkg::t_shift_ctrl             i_ctrl,
    input  wire logic [svenc_pkg::VALUE_BITS-1:0]   i_value,
    output svenc_pkg::t_digit                       o_digit
);
    import svenc_pkg::*;

    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] n_value;

    // Each advance drops one group; the sign bit fills from the top so the
    // upper bits keep comparing against the sign of the original value.
    always_comb begin
        n_value = r_value;
        if (i_ctrl.load) begin
            n_value = i_value;
        end else if (i_ctrl.advance) begin
            n_value = {{GROUP_BITS{r_value[VALUE_BITS-1]}},
                       r_value[VALUE_BITS-1:GROUP_BITS]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // The code may stop here when bit 6 of the group and every bit above it agree.
    assign o_digit.group   = r_value[GROUP_BITS-1:0];
    assign o_digit.uniform = (&r_value[VALUE_BITS-1:GROUP_BITS-1])
                           | ~(|r_value[VALUE_BITS-1:GROUP_BITS-1]);
    assign o_digit.low_bit = r_value[0];

endmodule

`default_nettype wire

FILE: hdl/signed_varint_encoder_unit.sv
// The first code byte is offered in the cycle after the value is accepted.
// A value of n code bytes (1 to 10) holds the unit until its last byte is taken, one byte
// per cycle while o_out.ready is high, from the group shift register; the next value is
// taken in the cycle its predecessor's last byte is taken.
// Reset (synchronous, active low) returns the unit to idle; the value register is not cleared.
`default_nettype none

module signed_varint_encoder_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    svenc_in_if.sink   i_in,
    svenc_out_if.source o_out
);
    import svenc_pkg::*;

    `include "signed_varint_encoder_unit_assert.svh"

    t_state               r_state;
    t_state               n_state;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   n_count;
    t_shift_ctrl          s_ctrl;
    t_digit               s_digit;
    logic                 s_in_req;
    logic                 s_out_req;
    logic                 s_tenth;
    logic                 s_last;

    svenc_shift u_shift (
        .i_clk   (i_clk),
        .i_ctrl  (s_ctrl),
        .i_value (i_in.value),
        .o_digit (s_digit)
    );

    assign s_tenth   = (r_count == LAST_INDEX);
    assign s_last    = s_tenth | s_digit.uniform;
    assign s_out_req = o_out.valid & o_out.ready;
    assign s_in_req  = i_in.valid & i_in.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_in_req) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (s_out_req && s_last && !s_in_req) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and shift control.
    always_comb begin
        i_in.ready      = 1'b0;
        o_out.valid     = 1'b0;
        s_ctrl.load     = 1'b0;
        s_ctrl.advance  = 1'b0;
        n_count         = r_count;
        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ST_EMIT: begin
                o_out.valid = 1'b1;
                // The next value may enter as the last byte leaves.
                i_in.ready  = s_out_req & s_last;
                if (s_out_req) begin
                    if (s_last) begin
                        n_count = '0;
                    end else begin
                        s_ctrl.advance = 1'b1;
                        n_count        = r_count + COUNT_W'(1);
                    end
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
        if (s_in_req) begin
            s_ctrl.load = 1'b1;
            n_count     = '0;
        end
    end

    // The tenth byte carries only the top bit of the value and no stop mark.
    always_comb begin
        if (s_tenth) begin
            o_out.code_byte = {{(BYTE_BITS-1){1'b0}}, s_digit.low_bit};
        end else begin
            o_out.code_byte = {s_digit.uniform, s_digit.group};
        end
        o_out.last = s_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    `SVENC_ASSERT_NOW(a_count_range, 1'b1, r_count <= LAST_INDEX)
    `SVENC_ASSERT_NOW(a_idle_count, r_state == ST_IDLE, r_count == '0)
    `SVENC_ASSERT_NEXT(a_count_step, s_out_req && !s_last,
                       (r_count == $past(r_count) + COUNT_W'(1)) && (r_state == ST_EMIT))
    `SVENC_ASSERT_NOW(a_tenth_byte, o_out.valid && s_tenth,
                      o_out.last && !o_out.code_byte[BYTE_BITS-1])

endmodule

`default_nettype wire

FILE: bench/signed_varint_encoder_checker.sv
`default_nettype none

module signed_varint_encoder_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    svenc_in_if       i_in_mon,
    svenc_out_if      i_out_mon,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_bytes_checked,
    output int        o_full_codes
);
    timeunit 1ns;
    timeprecision 1ps;

    import svenc_pkg::*;

    localparam logic [BYTE_BITS-1:0] STOP_MARK = 8'h80;

    typedef struct packed {
        logic [BYTE_BITS-1:0] code_byte;
        logic                 last;
    } t_code_entry;

    t_code_entry expected_code_q[$];
    int          fail_count;
    int          bytes_checked;
    int          full_codes;

    assign o_fail_count    = fail_count;
    assign o_pending       = expected_code_q.size();
    assign o_bytes_checked = bytes_checked;
    assign o_full_codes    = full_codes;

    initial begin
        fail_count    = 0;
        bytes_checked = 0;
        full_codes    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] ERROR: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Queues the code bytes of one value, low group first. The stop test looks at
    // bits 6 and up of the current group: if they all agree, the value sign-extends.
    function automatic void predict_code(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0] span;
        logic [BYTE_BITS-1:0]  codes [MAX_BYTES];
        int                    count;
        int                    width;
        t_code_entry           entry;
        v        = value;
        width    = VALUE_BITS - GROUP_BITS;
        count    = 1;
        codes[0] = {1'b0, v[GROUP_BITS-1:0]};
        while (count < MAX_BYTES) begin
            span = (64'd1 << width) - 64'd1;
            if ((((v >> GROUP_BITS) ^ (v >> (GROUP_BITS - 1))) & span) == '0) begin
                codes[count-1] = codes[count-1] | STOP_MARK;
                break;
            end
            v            = v >> GROUP_BITS;
            codes[count] = {1'b0, v[GROUP_BITS-1:0]};
            count++;
            width = (width > GROUP_BITS) ? width - GROUP_BITS : 1;
        end
        if (count == MAX_BYTES) full_codes++;
        for (int i = 0; i < count; i++) begin
            entry.code_byte = codes[i];
            entry.last      = (i == count - 1);
            expected_code_q.push_back(entry);
        end
    endfunction

    always @(posedge i_clk) begin
        t_code_entry want;
        if (i_rst_n) begin
            // Bytes leave no earlier than the cycle after their value is taken, so check first.
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_code_q.size() == 0) begin
                    report_mismatch("code byte with nothing expected",
                                    int'(i_out_mon.code_byte), 0);
                end else begin
                    want = expected_code_q.pop_front();
                    bytes_checked++;
                    if (i_out_mon.code_byte !== want.code_byte)
                        report_mismatch("code_byte", int'(i_out_mon.code_byte),
                                        int'(want.code_byte));
                    if (i_out_mon.last !== want.last)
                        report_mismatch("last", int'(i_out_mon.last), int'(want.last));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                predict_code(i_in_mon.value);
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;

    svenc_in_if  in_if ();
    svenc_out_if out_if ();

    int fail_count;
    int pending;
    int bytes_checked;
    int full_codes;
    int values_sent;
    bit calm;

    signed_varint_encoder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    signed_varint_encoder_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_if),
        .i_out_mon       (out_if),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_checked (bytes_checked),
        .o_full_codes    (full_codes)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d code bytes still expected", pending);
        $display("Mismatches found");
        $finish;
    end

    // Mostly no gap, some short ones and now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random value that fits in a random number of signed bits, so code lengths spread.
    function automatic logic signed [63:0] random_value();
        logic signed [63:0] r;
        int                 sh;
        r  = {$urandom, $urandom};
        sh = 64 - $urandom_range(1, 64);
        r  = (r <<< sh) >>> sh;
        return r;
    endfunction

    // Entered just after a rising edge; returns at the edge that takes the request.
    task automatic send_value(input logic signed [63:0] v);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= v;
        do @(posedge i_clk); while (!in_if.ready);
        values_sent++;
    endtask

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                stall--;
            end else begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < 20) stall = pick_gap();
            end
        end
    end

    initial begin
        logic signed [63:0] one;
        int                 waited;
        one          = 64'sd1;
        calm         = 1'b0;
        values_sent  = 0;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.value  = '0;
        out_if.ready = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        send_value(64'sd0);
        send_value(-64'sd1);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'h8000_0000_0000_0000);
        // Largest positive value of each length, and the negative value just below
        // that length's range, which needs one byte more.
        for (int k = 1; k <= 9; k++) begin
            send_value((one <<< (7 * k - 1)) - 1);
            send_value(-(one <<< (7 * k - 1)) - 1);
        end

        for (int i = 0; i < 220; i++) begin
            calm = ((i / 40) % 3) == 1;
            send_value(random_value());
        end
        calm = 1'b0;
        @(negedge i_clk);
        in_if.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        waited = 0;
        while (waited < 20) begin
            @(posedge i_clk);
            waited++;
        end

        $display("Encoded %0d values into %0d checked code bytes, %0d of them ten-byte codes.",
                 values_sent, bytes_checked, full_codes);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
